FILE: hw/rtl/ksta_pkg.sv
// Package for the key slot toggle allocator: sizes, transfer payload types,
// result status codes and the sequencer state type. No dependencies.
package ksta_pkg;

  localparam int SLOT_COUNT = 32;
  localparam int KEY_BITS   = 64;
  localparam int TIME_BITS  = 32;

  localparam int SLOT_IDX_BITS = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_BITS      = $clog2(SLOT_COUNT + 1);

  localparam logic [1:0] ST_ADMITTED = 2'd0;
  localparam logic [1:0] ST_RELEASED = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [63:0] entry_key;
    logic [31:0] entry_time;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] slot_number;
    logic [5:0] occupied_count;
    logic [5:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [TIME_BITS-1:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

endpackage

FILE: hw/rtl/key_slot_toggle_allocator.sv
// Top level of the key slot toggle allocator: sequencer, valid bits and counts.
// Depends on ksta_pkg and on ksta_ram for the key and timestamp store.
//
// Each request transfer carries a key and a timestamp. If a slot holds the key, that
// slot is freed and the response reports it released; otherwise the lowest free slot
// (numbered from 1) takes the key and the response reports it admitted, or full with
// slot 0 when no slot is free. Every response carries the occupied and free counts
// after the request. The slot store has a single read port, and the scan reads one
// slot per cycle through one key comparator, then does the last compare in S_DRAIN
// and the write-back in S_FINISH, once the output register can take the response.
// Valid bits are flip-flops cleared by reset, so no clearing pass is needed. A finished
// response waits in an output register, and the next request is taken meanwhile.
module key_slot_toggle_allocator
  import ksta_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  state_t state;
  state_t state_next;

  logic [SLOT_COUNT-1:0]    slot_valid;
  logic [CNT_BITS-1:0]      held;
  logic [CNT_BITS-1:0]      held_next;
  logic [KEY_BITS-1:0]      cur_key;
  logic [TIME_BITS-1:0]     cur_time;
  logic [SLOT_IDX_BITS-1:0] scan_idx;
  logic [SLOT_IDX_BITS-1:0] cmp_idx;
  logic                     cmp_pending;
  logic                     hit_found;
  logic [SLOT_IDX_BITS-1:0] hit_idx;
  logic                     empty_found;
  logic [SLOT_IDX_BITS-1:0] empty_idx;

  logic   accept;
  logic   rd_en;
  logic   commit;
  logic   scan_last;
  logic   wr_en;
  entry_t wr_entry;
  entry_t rd_entry;
  rsp_t   rsp_next;

  ksta_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(SLOT_COUNT)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(empty_idx),
    .wr_data(wr_entry),
    .rd_en  (rd_en),
    .rd_addr(scan_idx),
    .rd_data(rd_entry)
  );

  assign scan_last = (scan_idx == SLOT_IDX_BITS'(SLOT_COUNT - 1));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    req_stall = 1'b1;
    rd_en     = 1'b0;
    commit    = 1'b0;
    case (state)
      S_IDLE: begin
        req_stall = 1'b0;
      end
      S_SCAN: begin
        rd_en = 1'b1;
      end
      S_FINISH: begin
        commit = !rsp_valid || !rsp_stall;
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  assign accept = req_valid && !req_stall;

  assign wr_en          = commit && !hit_found && empty_found;
  assign wr_entry.key   = cur_key;
  assign wr_entry.stamp = cur_time;

  always_comb begin
    held_next            = held;
    rsp_next.status      = ST_FULL;
    rsp_next.slot_number = 6'd0;
    if (hit_found) begin
      if (held != '0) begin
        held_next = held - CNT_BITS'(1);
      end
      rsp_next.status      = ST_RELEASED;
      rsp_next.slot_number = 6'(CNT_BITS'(hit_idx) + CNT_BITS'(1));
    end else if (empty_found) begin
      if (held != CNT_BITS'(SLOT_COUNT)) begin
        held_next = held + CNT_BITS'(1);
      end
      rsp_next.status      = ST_ADMITTED;
      rsp_next.slot_number = 6'(CNT_BITS'(empty_idx) + CNT_BITS'(1));
    end
    rsp_next.occupied_count = 6'(held_next);
    rsp_next.free_count     = 6'(CNT_BITS'(SLOT_COUNT) - held_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      slot_valid  <= '0;
      held        <= '0;
      cmp_pending <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cmp_pending <= rd_en;
      if (commit) begin
        held      <= held_next;
        rsp_valid <= 1'b1;
        if (hit_found) begin
          slot_valid[hit_idx] <= 1'b0;
        end else if (empty_found) begin
          slot_valid[empty_idx] <= 1'b1;
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_key     <= req.entry_key[KEY_BITS-1:0];
      cur_time    <= req.entry_time;
      scan_idx    <= '0;
      hit_found   <= 1'b0;
      empty_found <= 1'b0;
    end else begin
      if (rd_en && !scan_last) begin
        scan_idx <= scan_idx + SLOT_IDX_BITS'(1);
      end
      if (cmp_pending) begin
        if (slot_valid[cmp_idx]) begin
          if (!hit_found && (rd_entry.key == cur_key)) begin
            hit_found <= 1'b1;
            hit_idx   <= cmp_idx;
          end
        end else if (!empty_found) begin
          empty_found <= 1'b1;
          empty_idx   <= cmp_idx;
        end
      end
    end
    if (rd_en) begin
      cmp_idx <= scan_idx;
    end
    if (commit) begin
      rsp <= rsp_next;
    end
  end

endmodule

FILE: hw/rtl/ksta_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; no package dependencies.
module ksta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for key_slot_toggle_allocator: directed and random request transfers
// checked against a slot-table predictor kept in a small scoreboard class.
// Depends on ksta_pkg and the allocator RTL.
module tb;
  import ksta_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned ITEM_TARGET = 1200;
  localparam int          POOL_SIZE   = 48;

  class key_slot_ledger;
    bit                   valid_q [SLOT_COUNT];
    logic [KEY_BITS-1:0]  key_q   [SLOT_COUNT];
    logic [TIME_BITS-1:0] stamp_q [SLOT_COUNT];
    int unsigned          held;
    rsp_t                 expected_q[$];
    int unsigned          mismatches;

    function new();
      foreach (valid_q[i]) valid_q[i] = 1'b0;
      held = 0;
      mismatches = 0;
    endfunction

    function bit holds(logic [63:0] key);
      foreach (valid_q[i]) begin
        if (valid_q[i] && key_q[i] == key[KEY_BITS-1:0]) return 1'b1;
      end
      return 1'b0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_request(req_t item);
      logic [KEY_BITS-1:0] key;
      int   hit;
      int   empty;
      rsp_t r;
      key = item.entry_key[KEY_BITS-1:0];
      hit = -1;
      empty = -1;
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (valid_q[i]) begin
          if (hit < 0 && key_q[i] == key) hit = i;
        end else if (empty < 0) begin
          empty = i;
        end
      end
      if (hit >= 0) begin
        valid_q[hit] = 1'b0;
        if (held > 0) held--;
        r.status = ST_RELEASED;
        r.slot_number = 6'(hit + 1);
      end else if (empty >= 0) begin
        valid_q[empty] = 1'b1;
        key_q[empty] = key;
        stamp_q[empty] = item.entry_time;
        if (held < SLOT_COUNT) held++;
        r.status = ST_ADMITTED;
        r.slot_number = 6'(empty + 1);
      end else begin
        r.status = ST_FULL;
        r.slot_number = '0;
      end
      r.occupied_count = 6'(held);
      r.free_count = 6'(SLOT_COUNT - held);
      expected_q.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t exp;
      if (expected_q.size() == 0) begin
        $error("response transfer with no request outstanding: %h", got);
        mismatches++;
        return;
      end
      exp = expected_q.pop_front();
      if (got.status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, got.status);
        mismatches++;
      end
      if (got.slot_number !== exp.slot_number) begin
        $error("slot_number: expected %0d, got %0d", exp.slot_number, got.slot_number);
        mismatches++;
      end
      if (got.occupied_count !== exp.occupied_count) begin
        $error("occupied_count: expected %0d, got %0d", exp.occupied_count,
               got.occupied_count);
        mismatches++;
      end
      if (got.free_count !== exp.free_count) begin
        $error("free_count: expected %0d, got %0d", exp.free_count, got.free_count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  key_slot_ledger ledger = new();
  int unsigned    cycles = 0;
  int unsigned    sent = 0;
  bit             quiet = 1'b0;
  logic [63:0]    key_pool [POOL_SIZE];

  key_slot_toggle_allocator u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("key_slot_toggle_allocator verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp_stall <= !quiet && ($urandom_range(99) < 23);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) ledger.check_response(rsp);
  end

  task automatic send_request(input logic [63:0] key, input logic [31:0] stamp);
    req_t item;
    item.entry_key = key;
    item.entry_time = stamp;
    if (!quiet && $urandom_range(99) < 23) begin
      req_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 23) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    ledger.note_request(item);
    sent++;
  endtask

  task automatic drain_results();
    if (ledger.pending() != 0) begin
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clk);
    end
  endtask

  function automatic logic [31:0] random_stamp();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int          mode;
    int          seg_len;
    int          idx;
    int          tries;
    logic [63:0] key;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = {$urandom, $urandom};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(64'h0, 32'h0);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(64'h0, 32'h1234_5678);
    send_request(64'h1, 32'h5);
    send_request(64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    send_request(64'h8000_0000_0000_0000, 32'h8000_0000);
    send_request(64'h5555_5555_5555_5555, 32'h5555_5555);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA);
    send_request(64'h8000_0000_0000_0000, 32'h0);
    send_request(64'h5555_5555_5555_5555, 32'h0);
    send_request(64'h0000_0001_0000_0000, 32'h7FFF_FFFF);
    send_request(64'h1, 32'h0);
    send_request(64'hAAAA_AAAA_AAAA_AAAA, 32'h0);
    send_request(64'h0000_0001_0000_0000, 32'h0);
    drain_results();

    while (sent < ITEM_TARGET) begin
      quiet = (sent >= 500 && sent < 800);
      if ($urandom_range(5) == 0) drain_results();
      mode = $urandom_range(99);
      seg_len = $urandom_range(60, 10);
      repeat (seg_len) begin
        idx = $urandom_range(POOL_SIZE - 1);
        if (mode < 35) begin
          tries = 0;
          while (ledger.holds(key_pool[idx]) && tries < 16) begin
            idx = $urandom_range(POOL_SIZE - 1);
            tries++;
          end
        end else if (mode < 60) begin
          tries = 0;
          while (!ledger.holds(key_pool[idx]) && tries < 16) begin
            idx = $urandom_range(POOL_SIZE - 1);
            tries++;
          end
        end else if (mode < 70) begin
          if (!ledger.holds(key_pool[idx])) key_pool[idx] = {$urandom, $urandom};
        end
        key = key_pool[idx];
        send_request(key, random_stamp());
      end
    end
    quiet = 1'b0;

    drain_results();
    repeat (40) @(posedge clk);
    if (ledger.mismatches == 0) begin
      $display("key_slot_toggle_allocator verification clean");
    end else begin
      $display("key_slot_toggle_allocator verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/ksta_pkg.sv
hw/rtl/ksta_ram.sv
hw/rtl/key_slot_toggle_allocator.sv
dv/tb.sv
